// ===== src/mrlr_pkg.sv =====
package mrlr_pkg;

    // default sizes
    localparam int BUF_BYTES_DEF = 8192;
    localparam int READERS_DEF   = 4;
    localparam int MAX_BURST_DEF = 32;

    // command codes
    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_UNSUB  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_DUMP   = 3'd4
    } cmd_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_PLAN,
        ST_ADDR,
        ST_EMIT
    } state_t;

    // input item
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic [1:0] reader;
        logic [5:0] max_len;
    } req_t;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] slot;
        logic       slot_granted;
        logic       last;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic do_write;
        logic do_subscribe;
        logic do_unsub;
        logic take;
        logic empty_now;
        logic calc;
        logic plan;
        logic setup;
        logic emit;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic rd_ok;
        logic n_zero;
        logic emit_done;
    } stat_t;

endpackage

// ===== src/mrlr_ctrl.sv =====
module mrlr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2:0]      command,
    input  mrlr_pkg::stat_t stat,
    output mrlr_pkg::ctrl_t ctrl,
    output logic            busy
);

    mrlr_pkg::state_t state_reg;
    mrlr_pkg::state_t state_next;
    logic             accept;

    assign accept = start && (state_reg == mrlr_pkg::ST_IDLE);
    assign busy   = (state_reg != mrlr_pkg::ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrlr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrlr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if ((command == mrlr_pkg::CMD_READ && stat.rd_ok) ||
                        command == mrlr_pkg::CMD_DUMP)
                    begin
                        state_next = mrlr_pkg::ST_CALC;
                    end
                end
            end
            mrlr_pkg::ST_CALC:
            begin
                state_next = mrlr_pkg::ST_PLAN;
            end
            mrlr_pkg::ST_PLAN:
            begin
                state_next = stat.n_zero ? mrlr_pkg::ST_IDLE : mrlr_pkg::ST_ADDR;
            end
            mrlr_pkg::ST_ADDR:
            begin
                state_next = mrlr_pkg::ST_EMIT;
            end
            mrlr_pkg::ST_EMIT:
            begin
                if (stat.emit_done)
                begin
                    state_next = mrlr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrlr_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            mrlr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        mrlr_pkg::CMD_WRITE: ctrl.do_write     = 1'b1;
                        mrlr_pkg::CMD_SUB:   ctrl.do_subscribe = 1'b1;
                        mrlr_pkg::CMD_UNSUB: ctrl.do_unsub     = 1'b1;
                        mrlr_pkg::CMD_READ:
                        begin
                            ctrl.take      = stat.rd_ok;
                            ctrl.empty_now = !stat.rd_ok;
                        end
                        mrlr_pkg::CMD_DUMP:  ctrl.take         = 1'b1;
                        default:             ctrl              = '0;
                    endcase
                end
            end
            mrlr_pkg::ST_CALC: ctrl.calc  = 1'b1;
            mrlr_pkg::ST_PLAN: ctrl.plan  = 1'b1;
            mrlr_pkg::ST_ADDR: ctrl.setup = 1'b1;
            mrlr_pkg::ST_EMIT: ctrl.emit  = 1'b1;
            default:           ctrl       = '0;
        endcase
    end

endmodule

// ===== src/mrlr_datapath.sv =====
module mrlr_datapath #(
    parameter int BUF_BYTES = mrlr_pkg::BUF_BYTES_DEF,
    parameter int READERS   = mrlr_pkg::READERS_DEF,
    parameter int MAX_BURST = mrlr_pkg::MAX_BURST_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mrlr_pkg::req_t  request,
    input  mrlr_pkg::ctrl_t ctrl,
    output mrlr_pkg::stat_t stat,
    output mrlr_pkg::res_t  result,
    output logic            result_valid
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int LW = $clog2(MAX_BURST + 1);
    localparam logic [31:0] BUF32 = 32'(BUF_BYTES);

    // byte memory, undefined until written
    logic [7:0]    byte_mem [BUF_BYTES];
    logic [7:0]    mem_q_reg;

    // ring and reader state
    logic [31:0]   tw_reg;
    logic [READERS-1:0] active_reg;
    logic [31:0]   pos_reg [READERS];

    // per-command working registers
    logic          is_read_reg;
    logic [RW-1:0] rd_reg;
    logic [LW-1:0] lim_reg;
    logic [31:0]   diff_reg;
    logic [LW-1:0] n_reg;
    logic [LW-1:0] cnt_reg;
    logic [31:0]   addr_reg;

    // result registers
    mrlr_pkg::res_t single_reg;
    mrlr_pkg::res_t single_next;
    logic           single_vld_reg;
    logic           emit_vld_reg;
    logic           emit_last_reg;

    logic [31:0]   oldest;
    logic [RW-1:0] req_rd;
    logic          free_found;
    logic [RW-1:0] free_idx;
    logic          clamp;
    logic [31:0]   avail;
    logic [LW-1:0] n_next;
    logic [31:0]   diff_next;
    logic [31:0]   start_next;
    logic [LW-1:0] lim_next;

    assign oldest = (tw_reg > BUF32) ? (tw_reg - BUF32) : 32'd0;
    assign req_rd = RW'(request.reader);

    // status back to the controller
    assign stat.rd_ok     = (32'(request.reader) < 32'(READERS));
    assign stat.n_zero    = (n_next == '0);
    assign stat.emit_done = (cnt_reg == LW'(1));

    // lowest free reader slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = READERS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = RW'(i);
            end
        end
    end

    // burst limit saturation
    assign lim_next = (32'(request.max_len) > 32'(MAX_BURST)) ?
                      LW'(MAX_BURST) : LW'(request.max_len);

    // available count, read or dump
    assign diff_next = is_read_reg ? (tw_reg - pos_reg[rd_reg]) :
                       ((tw_reg > BUF32) ? BUF32 : tw_reg);

    // clamp to held bytes and limit
    assign clamp  = (diff_reg > BUF32);
    assign avail  = clamp ? BUF32 : diff_reg;
    assign n_next = (avail < 32'(lim_reg)) ? LW'(avail) : lim_reg;

    // first position to emit
    assign start_next = is_read_reg ? pos_reg[rd_reg] : (tw_reg - 32'(n_reg));

    // single result: subscribe grant or empty read/dump
    always_comb
    begin
        single_next      = '0;
        single_next.last = 1'b1;
        if (ctrl.do_subscribe)
        begin
            single_next.slot         = free_found ? 2'(free_idx) : 2'd0;
            single_next.slot_granted = free_found;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.do_write)
        begin
            byte_mem[tw_reg[AW-1:0]] <= request.data_byte;
        end
        if (ctrl.emit)
        begin
            mem_q_reg <= byte_mem[addr_reg[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg         <= '0;
            active_reg     <= '0;
            single_vld_reg <= 1'b0;
            emit_vld_reg   <= 1'b0;
            for (int i = 0; i < READERS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            single_vld_reg <= ctrl.do_subscribe || ctrl.empty_now ||
                              (ctrl.plan && (n_next == '0));
            emit_vld_reg   <= ctrl.emit;
            if (ctrl.do_write)
            begin
                tw_reg <= tw_reg + 32'd1;
            end
            if (ctrl.do_subscribe && free_found)
            begin
                active_reg[free_idx] <= 1'b1;
                pos_reg[free_idx]    <= oldest;
            end
            if (ctrl.do_unsub && stat.rd_ok)
            begin
                active_reg[req_rd] <= 1'b0;
            end
            // skip past overwritten bytes
            if (ctrl.plan && is_read_reg && clamp)
            begin
                pos_reg[rd_reg] <= tw_reg - BUF32;
            end
            // advance reader past the emitted bytes
            if (ctrl.emit && stat.emit_done && is_read_reg)
            begin
                pos_reg[rd_reg] <= addr_reg + 32'd1;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            is_read_reg <= (request.command == mrlr_pkg::CMD_READ);
            rd_reg      <= req_rd;
            lim_reg     <= lim_next;
        end
        if (ctrl.calc)
        begin
            diff_reg <= diff_next;
        end
        if (ctrl.plan)
        begin
            n_reg <= n_next;
        end
        if (ctrl.setup)
        begin
            addr_reg <= start_next;
            cnt_reg  <= n_reg;
        end
        else if (ctrl.emit)
        begin
            addr_reg <= addr_reg + 32'd1;
            cnt_reg  <= cnt_reg - LW'(1);
        end
        emit_last_reg <= stat.emit_done;
        single_reg    <= single_next;
    end

    // result mux
    always_comb
    begin
        if (emit_vld_reg)
        begin
            result              = '0;
            result.out_byte     = mem_q_reg;
            result.has_byte     = 1'b1;
            result.last         = emit_last_reg;
        end
        else
        begin
            result = single_reg;
        end
    end
    assign result_valid = emit_vld_reg || single_vld_reg;

    // checks
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit_vld_reg && single_vld_reg))
        else $error("byte and single result in the same cycle");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> cnt_reg != '0)
        else $error("emit with zero bytes left");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_vld_reg && emit_last_reg) |=> !emit_vld_reg)
        else $error("byte emitted after last");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_write |=> tw_reg == $past(tw_reg) + 32'd1)
        else $error("write counter did not advance");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.setup |-> (n_reg <= lim_reg) && (n_reg != '0))
        else $error("burst length out of bounds");

endmodule

// ===== src/multi_reader_overwrite_log_ring.sv =====
// Overwrite trace ring with several readers.
// Input channel: request carries one command item, accepted at a rising edge with start high
// and busy low. Output channel: result carries one result item, valid for exactly one cycle
// while result_valid is high; the receiver cannot stall it, so nothing waits on the far side.
// Write and unsubscribe give no result; writes may come every cycle.
// Subscribe gives its grant on result the cycle after acceptance.
// Read and dump: busy stays high through CALC, PLAN and ADDR and while n bytes are emitted
// (n at most max_len saturated to MAX_BURST); bytes come one per cycle through the single
// memory read port, the first one after ADDR and the registered memory read, the last one
// marked by last. An empty read or dump stays busy through CALC and PLAN and gives one result
// with has_byte low; a read of a slot beyond READERS gives it the cycle after acceptance.
// Reset clears the write count, all reader flags and positions; the byte memory has no
// reset and needs no clearing pass, since only written bytes are ever read.
module multi_reader_overwrite_log_ring #(
    parameter int BUF_BYTES = mrlr_pkg::BUF_BYTES_DEF,
    parameter int READERS   = mrlr_pkg::READERS_DEF,
    parameter int MAX_BURST = mrlr_pkg::MAX_BURST_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mrlr_pkg::req_t request,
    output mrlr_pkg::res_t result,
    output logic           result_valid
);

    mrlr_pkg::ctrl_t ctrl;
    mrlr_pkg::stat_t stat;

    // sequencer
    mrlr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    // ring memory, reader state and result path
    mrlr_datapath #(
        .BUF_BYTES (BUF_BYTES),
        .READERS   (READERS),
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .ctrl         (ctrl),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
